// ----- hw/rtl/hpas_pkg.sv -----
`default_nettype none
package hpas_pkg;

  localparam int BUCKET_BITS        = 10;
  localparam int ENTRIES_PER_BUCKET = 8;
  localparam int PAGE_ORDER         = 12;
  localparam int ADDR_W             = 48;
  localparam int LEN_W              = 32;
  localparam int REQ_W              = 2;
  localparam int COUNT_W            = 21;
  localparam int TOTAL_W            = 14;

  localparam int SLOT_BITS  = (ENTRIES_PER_BUCKET > 1) ? $clog2(ENTRIES_PER_BUCKET) : 1;
  localparam int FILL_W     = $clog2(ENTRIES_PER_BUCKET + 1);
  localparam int ENTRY_AW   = BUCKET_BITS + SLOT_BITS;
  localparam int IN_DATA_W  = ADDR_W + LEN_W;
  localparam int OUT_DATA_W = 64;
  localparam int OUT_PAD_W  = OUT_DATA_W - 1 - 2 * COUNT_W - TOTAL_W;

  localparam logic [REQ_W-1:0] REQ_MARK  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_QUERY = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

  typedef struct packed {
    logic                   we;
    logic [BUCKET_BITS-1:0] waddr;
    logic [FILL_W-1:0]      wdata;
    logic [BUCKET_BITS-1:0] raddr;
  } fill_port_t;

  typedef struct packed {
    logic                we;
    logic [ENTRY_AW-1:0] waddr;
    logic [ADDR_W-1:0]   wdata;
    logic [ENTRY_AW-1:0] raddr;
  } entry_port_t;

  typedef struct packed {
    logic               found;
    logic [COUNT_W-1:0] pages_added;
    logic [COUNT_W-1:0] pages_dropped;
    logic [TOTAL_W-1:0] tracked_total;
  } result_t;

endpackage
`default_nettype wire

// ----- hw/rtl/hpas_ram.sv -----
`default_nettype none
module hpas_ram #(
  parameter int AW = 4,
  parameter int DW = 8
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [2**AW];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ----- hw/rtl/hpas_seq.sv -----
`default_nettype none
module hpas_seq
  import hpas_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [REQ_W-1:0]   in_req_i,
  input  wire logic [ADDR_W-1:0]  in_addr_i,
  input  wire logic [LEN_W-1:0]   in_len_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output result_t                 out_res_o,
  output fill_port_t              fill_o,
  input  wire logic [FILL_W-1:0]  fill_rdata_i,
  output entry_port_t             entry_o,
  input  wire logic [ADDR_W-1:0]  entry_rdata_i
);

  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_M_ROOM = 4'd2;
  localparam logic [3:0] S_M_SPAN = 4'd3;
  localparam logic [3:0] S_M_RD   = 4'd4;
  localparam logic [3:0] S_M_WR   = 4'd5;
  localparam logic [3:0] S_L_WAIT = 4'd6;
  localparam logic [3:0] S_L_FILL = 4'd7;
  localparam logic [3:0] S_L_RD   = 4'd8;
  localparam logic [3:0] S_L_CMP  = 4'd9;
  localparam logic [3:0] S_C_RD   = 4'd10;
  localparam logic [3:0] S_C_MOVE = 4'd11;
  localparam logic [3:0] S_DONE   = 4'd12;

  localparam logic [ADDR_W:0]   ADDR_SPAN  = (ADDR_W + 1)'(1) << ADDR_W;
  localparam logic [ADDR_W-1:0] PAGE_STEP  = ADDR_W'(1) << PAGE_ORDER;
  localparam logic [LEN_W:0]    PAGE_BYTES = (LEN_W + 1)'(1) << PAGE_ORDER;
  localparam logic [FILL_W-1:0] FILL_MAX   = FILL_W'(ENTRIES_PER_BUCKET);

  logic [3:0]             state_q, state_d;
  logic [BUCKET_BITS-1:0] init_idx_q, init_idx_d;
  logic                   enabled_q;
  logic [REQ_W-1:0]       req_q, req_d;
  logic [ADDR_W-1:0]      addr_q, addr_d;
  logic [LEN_W-1:0]       rem_q, rem_d;
  logic [ADDR_W:0]        room_q, room_d;
  logic [FILL_W-1:0]      n_q, n_d;
  logic [FILL_W-1:0]      idx_q, idx_d;
  logic                   found_q, found_d;
  logic [COUNT_W-1:0]     added_q, added_d;
  logic [COUNT_W-1:0]     dropped_q, dropped_d;
  logic [TOTAL_W-1:0]     total_q, total_d;
  logic                   out_valid_q, out_valid_d;
  result_t                res_q, res_d;

  logic [BUCKET_BITS-1:0] bucket;
  logic [FILL_W-1:0]      slot_sel;
  logic [FILL_W-1:0]      last_slot;

  assign bucket    = addr_q[PAGE_ORDER +: BUCKET_BITS];
  assign last_slot = n_q - FILL_W'(1);
  assign slot_sel  = (state_q == S_C_RD) ? last_slot : idx_q;

  always_comb begin
    state_d     = state_q;
    init_idx_d  = init_idx_q;
    req_d       = req_q;
    addr_d      = addr_q;
    rem_d       = rem_q;
    room_d      = room_q;
    n_d         = n_q;
    idx_d       = idx_q;
    found_d     = found_q;
    added_d     = added_q;
    dropped_d   = dropped_q;
    total_d     = total_q;
    out_valid_d = out_valid_q && !out_ready_i;
    res_d       = res_q;

    fill_o       = '0;
    fill_o.raddr = bucket;
    entry_o       = '0;
    entry_o.raddr = {bucket, slot_sel[SLOT_BITS-1:0]};

    case (state_q)
      S_INIT: begin
        fill_o.we    = 1'b1;
        fill_o.waddr = init_idx_q;
        fill_o.wdata = '0;
        init_idx_d   = init_idx_q + BUCKET_BITS'(1);
        if (&init_idx_q) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          req_d     = in_req_i;
          addr_d    = in_addr_i;
          rem_d     = in_len_i;
          found_d   = 1'b0;
          added_d   = '0;
          dropped_d = '0;
          idx_d     = '0;
          if (!enabled_q) begin
            state_d = S_DONE;
          end else begin
            case (in_req_i)
              REQ_MARK:  state_d = S_M_ROOM;
              REQ_QUERY: state_d = S_L_WAIT;
              REQ_CLEAR: state_d = S_L_WAIT;
              default:   state_d = S_DONE;
            endcase
          end
        end
      end
      S_M_ROOM: begin
        room_d  = ADDR_SPAN - {1'b0, addr_q};
        state_d = S_M_SPAN;
      end
      S_M_SPAN: begin
        if ({{(ADDR_W + 1 - LEN_W){1'b0}}, rem_q} > room_q) begin
          rem_d = room_q[LEN_W-1:0];
        end
        state_d = (rem_q == '0) ? S_DONE : S_M_RD;
      end
      S_M_RD: begin
        state_d = S_M_WR;
      end
      S_M_WR: begin
        if (fill_rdata_i < FILL_MAX) begin
          entry_o.we    = 1'b1;
          entry_o.waddr = {bucket, fill_rdata_i[SLOT_BITS-1:0]};
          entry_o.wdata = addr_q;
          fill_o.we     = 1'b1;
          fill_o.waddr  = bucket;
          fill_o.wdata  = fill_rdata_i + FILL_W'(1);
          total_d       = total_q + TOTAL_W'(1);
          added_d       = added_q + COUNT_W'(1);
        end else begin
          dropped_d = dropped_q + COUNT_W'(1);
        end
        addr_d = addr_q + PAGE_STEP;
        if ({1'b0, rem_q} <= PAGE_BYTES) begin
          rem_d   = '0;
          state_d = S_DONE;
        end else begin
          rem_d   = rem_q - PAGE_BYTES[LEN_W-1:0];
          state_d = S_M_RD;
        end
      end
      S_L_WAIT: begin
        state_d = S_L_FILL;
      end
      S_L_FILL: begin
        n_d     = fill_rdata_i;
        state_d = (fill_rdata_i == '0) ? S_DONE : S_L_RD;
      end
      S_L_RD: begin
        state_d = S_L_CMP;
      end
      S_L_CMP: begin
        if (entry_rdata_i == addr_q) begin
          found_d = 1'b1;
          state_d = (req_q == REQ_CLEAR) ? S_C_RD : S_DONE;
        end else if ((idx_q + FILL_W'(1)) == n_q) begin
          state_d = S_DONE;
        end else begin
          idx_d   = idx_q + FILL_W'(1);
          state_d = S_L_RD;
        end
      end
      S_C_RD: begin
        state_d = S_C_MOVE;
      end
      S_C_MOVE: begin
        entry_o.we    = 1'b1;
        entry_o.waddr = {bucket, idx_q[SLOT_BITS-1:0]};
        entry_o.wdata = entry_rdata_i;
        fill_o.we     = 1'b1;
        fill_o.waddr  = bucket;
        fill_o.wdata  = last_slot;
        if (total_q != '0) begin
          total_d = total_q - TOTAL_W'(1);
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d         = 1'b1;
          res_d.found         = found_q;
          res_d.pages_added   = added_q;
          res_d.pages_dropped = dropped_q;
          res_d.tracked_total = total_q;
          state_d             = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      init_idx_q  <= '0;
      enabled_q   <= 1'b0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      init_idx_q  <= init_idx_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        enabled_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    addr_q    <= addr_d;
    rem_q     <= rem_d;
    room_q    <= room_d;
    n_q       <= n_d;
    idx_q     <= idx_d;
    found_q   <= found_d;
    added_q   <= added_d;
    dropped_q <= dropped_d;
    res_q     <= res_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

`ifndef SYNTH
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("new transaction taken while one is in progress");

  a_total_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (total_q == $past(total_q)) || (total_q == $past(total_q) + TOTAL_W'(1))
             || (total_q == $past(total_q) - TOTAL_W'(1)))
    else $error("entry total moved by more than one");

  a_entry_with_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    entry_o.we |-> (fill_o.we && (fill_o.waddr == entry_o.waddr[ENTRY_AW-1 -: BUCKET_BITS])))
    else $error("entry written without bucket count update");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_DONE))
    else $error("result loaded outside done state");
`endif

endmodule
`default_nettype wire

// ----- hw/rtl/hashed_page_address_set.sv -----
`default_nettype none
// channel   dir  handshake                   payload
// s_axis    in   s_axis_tvalid/tready        tdata: address, byte_length; tuser: req_type
// m_axis    out  m_axis_tvalid/tready        tdata: found, pages_added, pages_dropped, tracked_total
// cfg       in   cfg_we_i                    cfg_wdata_i: tracker_enabled
//
// query: reads the bucket count, then reads and compares each bucket entry in turn; clear adds the slot move
// mark: clips the length to the address space, then reads and updates the bucket count for each page in turn
// the done step loads the result register; ignored requests go straight to it
// after reset an init pass zeroes all 1024 bucket counts; no input taken meanwhile
// a stalled result holds the block at its done step; the next transaction may wait there
module hashed_page_address_set
  import hpas_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic                  cfg_wdata_i,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,   // address, byte_length
  input  wire logic [REQ_W-1:0]      s_axis_tuser,   // req_type
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic      [OUT_DATA_W-1:0] m_axis_tdata    // found, pages_added, pages_dropped,
                                                     // tracked_total, zero pad
);

  fill_port_t        fill_port;
  entry_port_t       entry_port;
  logic [FILL_W-1:0] fill_rdata;
  logic [ADDR_W-1:0] entry_rdata;
  result_t           res;

  hpas_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_req_i      (s_axis_tuser),
    .in_addr_i     (s_axis_tdata[ADDR_W-1:0]),
    .in_len_i      (s_axis_tdata[ADDR_W +: LEN_W]),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_res_o     (res),
    .fill_o        (fill_port),
    .fill_rdata_i  (fill_rdata),
    .entry_o       (entry_port),
    .entry_rdata_i (entry_rdata)
  );

  hpas_ram #(
    .AW (BUCKET_BITS),
    .DW (FILL_W)
  ) u_fill_ram (
    .clk_i   (clk_i),
    .we_i    (fill_port.we),
    .waddr_i (fill_port.waddr),
    .wdata_i (fill_port.wdata),
    .raddr_i (fill_port.raddr),
    .rdata_o (fill_rdata)
  );

  hpas_ram #(
    .AW (ENTRY_AW),
    .DW (ADDR_W)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (entry_port.we),
    .waddr_i (entry_port.waddr),
    .wdata_i (entry_port.wdata),
    .raddr_i (entry_port.raddr),
    .rdata_o (entry_rdata)
  );

  assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, res.tracked_total, res.pages_dropped,
                         res.pages_added, res.found};

endmodule
`default_nettype wire
